FILE: rtl/mpsd_pkg.sv
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared types and constants for the minimum point set distance block.
// ----------------------------------------------------------------------------
package mpsd_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned POINT_W = 24;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned ENTRY_W = 2 * COORD_W;
  localparam int unsigned DIST_W  = 25;
  localparam int unsigned SQ_W    = 2 * DIST_W;
  localparam int unsigned STEP_W  = $clog2(DIST_W);

  localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_POINT  = 2'd1,
    MODE_END    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_EMIT
  } state_e;

endpackage

FILE: rtl/mpsd_ram.sv
// ----------------------------------------------------------------------------
// mpsd_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mpsd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/mpsd_sqrt.sv
// ----------------------------------------------------------------------------
// mpsd_sqrt
// Floor square root, one result bit per cycle (restoring digit recurrence).
// ----------------------------------------------------------------------------
module mpsd_sqrt
  import mpsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   radicand_i,
  output logic              done_o,
  output logic [DIST_W-1:0] root_o
);

  localparam int unsigned RW = DIST_W + 2;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SQ_W-1:0]   rad_q, rad_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [DIST_W-1:0] root_q, root_d;
  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;

  assign rem_sh = {rem_q[RW-3:0], rad_q[SQ_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIST_W - 1);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[DIST_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[DIST_W-2:0], 1'b0};
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/min_point_set_distance.sv
// ----------------------------------------------------------------------------
// min_point_set_distance
// Brute-force minimum Euclidean distance between a streamed path and a
// stored obstacle set, with a floor square root at the end of each path.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals
// in       input      in_valid_i / in_ready_o, mode_i, point_x_i, point_y_i,
//                     obstacle_x_i, obstacle_y_i
// out      output     out_valid_o / out_ready_i, min_distance_o,
//                     no_distance_o, obstacles_dropped_o
//
// Append, clear and a path point with an empty store complete in ST_IDLE.
// A path point issues one obstacle RAM read per cycle for each stored
// obstacle, then drains a three-stage difference, square and compare pipeline.
// End of path runs the bit-serial square root.
// The obstacle store has no clearing pass; the fill count guards it.
// A stalled output holds its result; the next item waits only at emit.
// ----------------------------------------------------------------------------
module min_point_set_distance
  import mpsd_pkg::*;
#(
  parameter int unsigned OBSTACLE_DEPTH = 1024,
  parameter int unsigned FRACTION_BITS  = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [MODE_W-1:0]         mode_i,
  input  logic signed [POINT_W-1:0] point_x_i,
  input  logic signed [POINT_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] obstacle_x_i,
  input  logic signed [COORD_W-1:0] obstacle_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [DIST_W-1:0]         min_distance_o,
  output logic                      no_distance_o,
  output logic                      obstacles_dropped_o
);

  localparam int unsigned AW     = (OBSTACLE_DEPTH > 1) ? $clog2(OBSTACLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(OBSTACLE_DEPTH + 1);
  localparam int unsigned OX_W   = COORD_W + FRACTION_BITS;
  localparam int unsigned DIFF_W = ((POINT_W > OX_W) ? POINT_W : OX_W) + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  state_e state_q, state_d;

  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic                     seen_q, seen_d;
  logic                     drop_q, drop_d;
  logic [SQ_W-1:0]          best_q;
  logic signed [POINT_W-1:0] px_q, py_q;

  logic                     in_fire;
  mode_e                    mode;
  logic                     store_full;
  logic                     last_issue;
  logic                     pipe_empty;

  logic                     wr_en;
  logic                     rd_en;
  logic [ENTRY_W-1:0]       rd_data;
  logic                     root_start;
  logic                     root_done;
  logic [DIST_W-1:0]        root;
  logic                     load_out;
  logic                     out_free;

  logic                     v1_q, v2_q, v3_q;
  logic signed [DIFF_W-1:0] ox, oy, dxs, dys;
  logic [DIFF_W-1:0]        dx_q, dy_q;
  logic [PROD_W-1:0]        sqx_q, sqy_q;
  logic [SUM_W-1:0]         sum;
  logic [SQ_W-1:0]          sq_sat;

  logic                     none_q;
  logic                     out_valid_q;
  logic [DIST_W-1:0]        min_distance_q;
  logic                     no_distance_q;
  logic                     dropped_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign mode       = mode_e'(mode_i);
  assign store_full = (count_q == CNT_W'(OBSTACLE_DEPTH));
  assign last_issue = (idx_q == count_q - 1'b1);
  assign pipe_empty = ~(v1_q | v2_q | v3_q);
  assign out_free   = ~out_valid_q | out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (mode == MODE_POINT && count_q != '0) begin
            state_d = ST_SCAN;
          end else if (mode == MODE_END) begin
            state_d = ST_ROOT;
          end
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and register updates
  always_comb begin
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    root_start = 1'b0;
    load_out   = 1'b0;
    count_d    = count_q;
    idx_d      = idx_q;
    seen_d     = seen_q;
    drop_d     = drop_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (mode)
            MODE_APPEND: begin
              if (store_full) begin
                drop_d = 1'b1;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            MODE_POINT: begin
              seen_d = 1'b1;
              idx_d  = '0;
            end
            MODE_END: begin
              root_start = 1'b1;
              seen_d     = 1'b0;
            end
            MODE_CLEAR: begin
              count_d = '0;
              drop_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        idx_d = idx_q + 1'b1;
      end
      ST_EMIT: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  mpsd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (OBSTACLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i ({obstacle_y_i, obstacle_x_i}),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // Distance pipeline: difference, square, sum and compare
  assign ox  = DIFF_W'(signed'(rd_data[COORD_W-1:0])) <<< FRACTION_BITS;
  assign oy  = DIFF_W'(signed'(rd_data[ENTRY_W-1:COORD_W])) <<< FRACTION_BITS;
  assign dxs = DIFF_W'(px_q) - ox;
  assign dys = DIFF_W'(py_q) - oy;
  assign sum = SUM_W'(sqx_q) + SUM_W'(sqy_q);
  assign sq_sat = (sum > SUM_W'(SQ_MAX)) ? SQ_MAX : sum[SQ_W-1:0];

  always_ff @(posedge clk_i) begin
    dx_q  <= dxs[DIFF_W-1] ? DIFF_W'(-dxs) : DIFF_W'(dxs);
    dy_q  <= dys[DIFF_W-1] ? DIFF_W'(-dys) : DIFF_W'(dys);
    sqx_q <= dx_q * dx_q;
    sqy_q <= dy_q * dy_q;
    if (in_fire && mode == MODE_POINT) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
  end

  mpsd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (best_q),
    .done_o     (root_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      idx_q          <= '0;
      seen_q         <= 1'b0;
      drop_q         <= 1'b0;
      best_q         <= SQ_MAX;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      v3_q           <= 1'b0;
      none_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      min_distance_q <= '0;
      no_distance_q  <= 1'b0;
      dropped_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      seen_q  <= seen_d;
      drop_q  <= drop_d;
      v1_q    <= rd_en;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (root_start) begin
        none_q <= ~seen_q | (count_q == '0) | (best_q == SQ_MAX);
        best_q <= SQ_MAX;
      end else if (v3_q && sq_sat < best_q) begin
        best_q <= sq_sat;
      end
      if (load_out) begin
        out_valid_q    <= 1'b1;
        min_distance_q <= none_q ? '0 : root;
        no_distance_q  <= none_q;
        dropped_q      <= drop_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign min_distance_o      = min_distance_q;
  assign no_distance_o       = no_distance_q;
  assign obstacles_dropped_o = dropped_q;

endmodule

FILE: dv/min_point_set_distance_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_point_set_distance_test
// Streams obstacle loads, path points, end-of-path and clear transfers into
// the block and checks every distance result against an in-bench predictor
// or, for the simple directed rows, against values written into the table.
// ----------------------------------------------------------------------------
module min_point_set_distance_test;
  import mpsd_pkg::*;

  localparam int unsigned OBSTACLE_DEPTH = 1024;
  localparam int unsigned FRACTION_BITS  = 8;
  localparam int unsigned QUIET_LIMIT    = 5000;
  localparam int unsigned TAIL_CYCLES    = 1100;
  localparam int unsigned HOLD_CYCLES    = 400;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              none;
    logic              drop;
  } distance_t;

  typedef struct {
    mode_e                     mode;
    logic signed [POINT_W-1:0] px;
    logic signed [POINT_W-1:0] py;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    bit                        typed;
    distance_t                 want;
  } stim_row_t;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic [MODE_W-1:0]         mode_i       = MODE_APPEND;
  logic signed [POINT_W-1:0] point_x_i    = '0;
  logic signed [POINT_W-1:0] point_y_i    = '0;
  logic signed [COORD_W-1:0] obstacle_x_i = '0;
  logic signed [COORD_W-1:0] obstacle_y_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b0;
  logic [DIST_W-1:0]         min_distance_o;
  logic                      no_distance_o;
  logic                      obstacles_dropped_o;

  logic signed [COORD_W-1:0] obs_x [OBSTACLE_DEPTH];
  logic signed [COORD_W-1:0] obs_y [OBSTACLE_DEPTH];
  int unsigned               obs_count = 0;
  logic [SQ_W-1:0]           best_sq   = SQ_MAX;
  bit                        path_seen = 1'b0;
  bit                        drop_seen = 1'b0;

  distance_t   pending_dist [$];
  int unsigned sent_items      = 0;
  int unsigned checked_results = 0;
  int unsigned mismatches      = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned hold_left       = 0;
  bit          hold_armed      = 1'b0;

  stim_row_t directed_rows [25] = '{
    '{MODE_END,    0,         0,         0,      0,      1, '{0, 1, 0}},
    '{MODE_POINT,  8388607,   -8388608,  32767,  -32768, 0, '{0, 0, 0}},
    '{MODE_END,    0,         0,         0,      0,      1, '{0, 1, 0}},
    '{MODE_APPEND, -1,        -1,        0,      0,      0, '{0, 0, 0}},
    '{MODE_END,    0,         0,         0,      0,      1, '{0, 1, 0}},
    '{MODE_POINT,  768,       1024,      -1,     -1,     0, '{0, 0, 0}},
    '{MODE_END,    5921370,   -1,        -1,     -1,     1, '{1280, 0, 0}},
    '{MODE_APPEND, 0,         0,         32767,  32767,  0, '{0, 0, 0}},
    '{MODE_APPEND, 0,         0,         -32768, -32768, 0, '{0, 0, 0}},
    '{MODE_POINT,  8388607,   8388607,   0,      0,      0, '{0, 0, 0}},
    '{MODE_END,    0,         0,         0,      0,      0, '{0, 0, 0}},
    '{MODE_POINT,  -8388608,  -8388608,  0,      0,      0, '{0, 0, 0}},
    '{MODE_END,    0,         0,         0,      0,      1, '{0, 0, 0}},
    '{MODE_POINT,  8388607,   -8388608,  0,      0,      0, '{0, 0, 0}},
    '{MODE_END,    0,         0,         0,      0,      0, '{0, 0, 0}},
    '{MODE_CLEAR,  -1,        -1,        -1,     -1,     0, '{0, 0, 0}},
    '{MODE_POINT,  0,         0,         0,      0,      0, '{0, 0, 0}},
    '{MODE_END,    0,         0,         0,      0,      1, '{0, 1, 0}},
    '{MODE_APPEND, 0,         0,         1,      0,      0, '{0, 0, 0}},
    '{MODE_POINT,  0,         0,         0,      0,      0, '{0, 0, 0}},
    '{MODE_CLEAR,  0,         0,         0,      0,      0, '{0, 0, 0}},
    '{MODE_END,    0,         0,         0,      0,      1, '{0, 1, 0}},
    '{MODE_APPEND, 0,         0,         -1,     -1,     0, '{0, 0, 0}},
    '{MODE_POINT,  -256,      -1,        0,      0,      0, '{0, 0, 0}},
    '{MODE_END,    0,         0,         0,      0,      0, '{0, 0, 0}}
  };

  min_point_set_distance #(
    .OBSTACLE_DEPTH(OBSTACLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .point_x_i          (point_x_i),
    .point_y_i          (point_y_i),
    .obstacle_x_i       (obstacle_x_i),
    .obstacle_y_i       (obstacle_y_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .min_distance_o     (min_distance_o),
    .no_distance_o      (no_distance_o),
    .obstacles_dropped_o(obstacles_dropped_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [DIST_W-1:0] floor_root(logic [SQ_W-1:0] n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(n)) root = trial;
    end
    return root[DIST_W-1:0];
  endfunction

  function automatic bit predict_transfer(input mode_e m,
                                          input logic signed [POINT_W-1:0] px,
                                          input logic signed [POINT_W-1:0] py,
                                          input logic signed [COORD_W-1:0] ox,
                                          input logic signed [COORD_W-1:0] oy,
                                          output distance_t res);
    longint          dx;
    longint          dy;
    longint unsigned sq;
    bit              none;
    res = '{default: '0};
    case (m)
      MODE_APPEND: begin
        if (obs_count < OBSTACLE_DEPTH) begin
          obs_x[obs_count] = ox;
          obs_y[obs_count] = oy;
          obs_count++;
        end else begin
          drop_seen = 1'b1;
        end
        return 1'b0;
      end
      MODE_POINT: begin
        path_seen = 1'b1;
        for (int unsigned i = 0; i < obs_count; i++) begin
          dx = longint'(px) - longint'(obs_x[i]) * (longint'(1) << FRACTION_BITS);
          dy = longint'(py) - longint'(obs_y[i]) * (longint'(1) << FRACTION_BITS);
          sq = longint'(dx * dx) + longint'(dy * dy);
          if (sq > 64'(SQ_MAX)) sq = 64'(SQ_MAX);
          if (sq < 64'(best_sq)) best_sq = sq[SQ_W-1:0];
        end
        return 1'b0;
      end
      MODE_CLEAR: begin
        obs_count = 0;
        drop_seen = 1'b0;
        return 1'b0;
      end
      default: begin
        none = !path_seen || obs_count == 0 || best_sq == SQ_MAX;
        res.distance = none ? '0 : floor_root(best_sq);
        res.none = none;
        res.drop = drop_seen;
        best_sq = SQ_MAX;
        path_seen = 1'b0;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    if ($urandom_range(0, 1) == 1) return COORD_W'($urandom);
    return COORD_W'(int'($urandom_range(0, 127)) - 64);
  endfunction

  function automatic logic [POINT_W-1:0] near_point(logic signed [COORD_W-1:0] c);
    int v;
    v = int'(c) * (1 << FRACTION_BITS) + int'($urandom_range(0, 4095)) - 2048;
    return v[POINT_W-1:0];
  endfunction

  task automatic report_mismatch(string field, longint unsigned got,
                                 longint unsigned want);
    mismatches++;
    $display("tb: mismatch on %s at result %0d: got %0d, want %0d",
             field, checked_results, got, want);
  endtask

  task automatic push_item(mode_e m,
                           logic signed [POINT_W-1:0] px,
                           logic signed [POINT_W-1:0] py,
                           logic signed [COORD_W-1:0] ox,
                           logic signed [COORD_W-1:0] oy,
                           bit typed = 1'b0,
                           distance_t want = '{default: '0});
    distance_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    point_x_i    <= px;
    point_y_i    <= py;
    obstacle_x_i <= ox;
    obstacle_y_i <= oy;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    if (predict_transfer(m, px, py, ox, oy, predicted))
      pending_dist.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_paths(int unsigned quota);
    int unsigned stop;
    int unsigned k;
    stop = sent_items + quota;
    while (sent_items < stop) begin
      if ($urandom_range(0, 99) < 15) begin
        push_item(mode_e'($urandom_range(0, 3)), POINT_W'($urandom), POINT_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
      end else begin
        if (obs_count > 40 || $urandom_range(0, 3) == 0)
          push_item(MODE_CLEAR, POINT_W'($urandom), POINT_W'($urandom),
                    COORD_W'($urandom), COORD_W'($urandom));
        repeat ($urandom_range(0, 6))
          push_item(MODE_APPEND, POINT_W'($urandom), POINT_W'($urandom),
                    rand_coord(), rand_coord());
        repeat ($urandom_range(0, 5)) begin
          if (obs_count != 0 && $urandom_range(0, 9) < 6) begin
            k = $urandom_range(0, obs_count - 1);
            push_item(MODE_POINT, near_point(obs_x[k]), near_point(obs_y[k]),
                      COORD_W'($urandom), COORD_W'($urandom));
          end else begin
            push_item(MODE_POINT, POINT_W'($urandom), POINT_W'($urandom),
                      COORD_W'($urandom), COORD_W'($urandom));
          end
        end
        push_item(MODE_END, POINT_W'($urandom), POINT_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    distance_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_dist.size() == 0) begin
        report_mismatch("unexpected result", min_distance_o, 0);
      end else begin
        want = pending_dist.pop_front();
        if (min_distance_o !== want.distance)
          report_mismatch("min_distance", min_distance_o, want.distance);
        if (no_distance_o !== want.none)
          report_mismatch("no_distance", no_distance_o, want.none);
        if (obstacles_dropped_o !== want.drop)
          report_mismatch("obstacles_dropped", obstacles_dropped_o, want.drop);
      end
      checked_results++;
    end
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: no transfer for %0d cycles", quiet_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 9;
    recv_idle_pct = 61;
    foreach (directed_rows[i])
      push_item(directed_rows[i].mode, directed_rows[i].px, directed_rows[i].py,
                directed_rows[i].ox, directed_rows[i].oy,
                directed_rows[i].typed, directed_rows[i].want);
    run_paths(180);
    wait_drained();

    send_idle_pct = 61;
    recv_idle_pct = 9;
    run_paths(180);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed    = 1'b1;
    run_paths(190);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("tb: %0d input transfers, %0d results checked, %0d mismatches",
             sent_items, checked_results, mismatches);
    $display("tb: covered empty and cleared stores, random paths, long output stall");
    if (mismatches == 0 && pending_dist.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
